// ===== hw/rtl/set_assoc_lru_cache_lookup_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the cache lookup block
// Concurrent assertion wrappers that compile away for synthesis.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_LRU_CACHE_LOOKUP_TOP_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_LOOKUP_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define SACL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SACL_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SACL_ASSERT(label, clk, rst, prop, msg)
`define SACL_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/sacl_pkg.sv =====
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types and constants of the set-associative cache lookup block.
// ----------------------------------------------------------------------------
package sacl_pkg;

   localparam int ADDRESS_W = 64;
   localparam int OUTCOME_W = 2;
   localparam int WAY_OUT_W = 3;
   localparam int COUNT_W   = 32;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam int SET_BITS_W    = 3;
   localparam int OFFSET_BITS_W = 6;
   localparam int WAYS_USED_W   = 4;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REG_SET_BITS    = 2'd0;
   localparam logic [1:0] REG_OFFSET_BITS = 2'd1;
   localparam logic [1:0] REG_WAYS_USED   = 2'd2;

   localparam logic [WAYS_USED_W-1:0] WAYS_USED_RESET = 4'd1;

   typedef enum logic [OUTCOME_W-1:0] {
      OUTCOME_HIT   = 2'd0,
      OUTCOME_FILL  = 2'd1,
      OUTCOME_EVICT = 2'd2
   } outcome_type;

   typedef struct packed {
      logic clear_step;
      logic accept;
      logic scan_step;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic scan_last;
   } dp_status_type;

endpackage

// ===== hw/rtl/sacl_intf.sv =====
// ----------------------------------------------------------------------------
// sacl_intf
// Request and response stream interfaces with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sacl_req_if;
   logic                           valid;
   logic                           ready;
   logic [sacl_pkg::ADDRESS_W-1:0] address;

   modport source (output valid, output address, input ready);
   modport sink (input valid, input address, output ready);
endinterface

interface sacl_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [sacl_pkg::OUTCOME_W-1:0] outcome;
   logic [sacl_pkg::WAY_OUT_W-1:0] way_used;
   logic [sacl_pkg::COUNT_W-1:0]   hits_total;
   logic [sacl_pkg::COUNT_W-1:0]   misses_total;
   logic [sacl_pkg::COUNT_W-1:0]   evictions_total;

   modport source (output valid, output outcome, output way_used, output hits_total,
                   output misses_total, output evictions_total, input ready);
   modport sink (input valid, input outcome, input way_used, input hits_total,
                 input misses_total, input evictions_total, output ready);
endinterface

// ===== hw/rtl/set_assoc_lru_cache_lookup_top.sv =====
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_lookup_top
// Set-associative cache tag lookup with LRU replacement and event counters.
//
// Each word on req_bus is one address. The block splits it into set and tag
// per the set_bits and offset_bits registers, searches the ways in use of
// that set, updates recency and the tag store, and returns one word on
// rsp_bus with the outcome, the way, and saturating hit/miss/eviction counts.
// One set is read from the tag RAM when the address is taken; the ways are
// then compared one per cycle, and the updated set is written back in a
// single commit cycle. A new address is taken only once the last one has
// been committed, and its result word is registered at the commit.
// The result sits in an output register: a stalled receiver does not stop
// the next address being taken and scanned, only its commit waits until
// the pending word is taken. After reset a clearing pass zeroes the tag
// RAM, one set per cycle, all 2**MAX_SET_BITS sets (64 by default); no
// address is taken meanwhile, while register writes on the csr port are.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_lookup_top #(
   parameter int MAX_SET_BITS = 6,
   parameter int MAX_WAYS     = 8,
   parameter int ADDR_BITS    = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   sacl_req_if.sink                        req_bus,
   sacl_rsp_if.source                      rsp_bus,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [sacl_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [sacl_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [sacl_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   logic [sacl_pkg::SET_BITS_W-1:0]    set_bits;
   logic [sacl_pkg::OFFSET_BITS_W-1:0] offset_bits;
   logic [sacl_pkg::WAYS_USED_W-1:0]   ways_used;
   sacl_pkg::ctrl_cmd_type             cmd;
   sacl_pkg::dp_status_type            status;
   logic                               req_ready;
   logic                               rsp_valid;

   sacl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (csr_psel),
      .penable     (csr_penable),
      .pwrite      (csr_pwrite),
      .paddr       (csr_paddr),
      .pwdata      (csr_pwdata),
      .prdata      (csr_prdata),
      .pready      (csr_pready),
      .set_bits    (set_bits),
      .offset_bits (offset_bits),
      .ways_used   (ways_used)
   );

   sacl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .status    (status)
   );

   sacl_dp #(
      .MAX_SET_BITS (MAX_SET_BITS),
      .MAX_WAYS     (MAX_WAYS),
      .ADDR_BITS    (ADDR_BITS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .set_bits            (set_bits),
      .offset_bits         (offset_bits),
      .ways_used           (ways_used),
      .req_address         (req_bus.address),
      .rsp_outcome         (rsp_bus.outcome),
      .rsp_way_used        (rsp_bus.way_used),
      .rsp_hits_total      (rsp_bus.hits_total),
      .rsp_misses_total    (rsp_bus.misses_total),
      .rsp_evictions_total (rsp_bus.evictions_total)
   );

   assign req_bus.ready = req_ready;
   assign rsp_bus.valid = rsp_valid;

endmodule

// ===== hw/rtl/sacl_ram.sv =====
// ----------------------------------------------------------------------------
// sacl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sacl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/sacl_csr.sv =====
// ----------------------------------------------------------------------------
// sacl_csr
// Configuration registers behind an APB-style port.
// ----------------------------------------------------------------------------
module sacl_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [sacl_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [sacl_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [sacl_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready,
   output logic [sacl_pkg::SET_BITS_W-1:0]      set_bits,
   output logic [sacl_pkg::OFFSET_BITS_W-1:0]   offset_bits,
   output logic [sacl_pkg::WAYS_USED_W-1:0]     ways_used
);

   logic [sacl_pkg::SET_BITS_W-1:0]    set_bits_ff, set_bits_in;
   logic [sacl_pkg::OFFSET_BITS_W-1:0] offset_bits_ff, offset_bits_in;
   logic [sacl_pkg::WAYS_USED_W-1:0]   ways_used_ff, ways_used_in;
   logic                               wr_stb;
   logic [1:0]                         reg_idx;

   assign pready  = 1'b1;
   assign wr_stb  = psel && penable && pwrite;
   assign reg_idx = paddr[3:2];

   always_comb begin
      set_bits_in    = set_bits_ff;
      offset_bits_in = offset_bits_ff;
      ways_used_in   = ways_used_ff;
      if (wr_stb) begin
         case (reg_idx)
            sacl_pkg::REG_SET_BITS: begin
               set_bits_in = pwdata[sacl_pkg::SET_BITS_W-1:0];
            end
            sacl_pkg::REG_OFFSET_BITS: begin
               offset_bits_in = pwdata[sacl_pkg::OFFSET_BITS_W-1:0];
            end
            sacl_pkg::REG_WAYS_USED: begin
               ways_used_in = pwdata[sacl_pkg::WAYS_USED_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         sacl_pkg::REG_SET_BITS:    prdata = sacl_pkg::CSR_DATA_W'(set_bits_ff);
         sacl_pkg::REG_OFFSET_BITS: prdata = sacl_pkg::CSR_DATA_W'(offset_bits_ff);
         sacl_pkg::REG_WAYS_USED:   prdata = sacl_pkg::CSR_DATA_W'(ways_used_ff);
         default:                   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff    <= '0;
         offset_bits_ff <= '0;
         ways_used_ff   <= sacl_pkg::WAYS_USED_RESET;
      end else begin
         set_bits_ff    <= set_bits_in;
         offset_bits_ff <= offset_bits_in;
         ways_used_ff   <= ways_used_in;
      end
   end

   assign set_bits    = set_bits_ff;
   assign offset_bits = offset_bits_ff;
   assign ways_used   = ways_used_ff;

endmodule

// ===== hw/rtl/sacl_ctrl.sv =====
// ----------------------------------------------------------------------------
// sacl_ctrl
// Sequencer for clearing, lookup scan, commit and response handshake.
// ----------------------------------------------------------------------------
`include "set_assoc_lru_cache_lookup_top_defines.svh"

module sacl_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output sacl_pkg::ctrl_cmd_type  cmd,
   input  sacl_pkg::dp_status_type status
);

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_SCAN   = 4'b0100,
      ST_COMMIT = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign req_ready = (state_ff == ST_IDLE);
   // The result register may be reloaded in the same cycle its word is taken.
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (slot_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `SACL_ASSERT(a_one_cmd, clock, reset, $onehot0({cmd.clear_step, cmd.accept, cmd.scan_step, cmd.commit}), "more than one datapath command")
   `SACL_ASSERT(a_rsp_after_commit, clock, reset, $rose(rsp_valid_ff) |-> $past(cmd.commit), "response raised without a commit")
   `SACL_ASSERT(a_accept_scan, clock, reset, cmd.accept |=> (state_ff == ST_SCAN), "accepted word did not start a scan")
   `SACL_ASSERT(a_clear_done, clock, reset, $fell(state_ff == ST_CLEAR) |-> $past(status.clear_last), "clearing pass left early")

endmodule

// ===== hw/rtl/sacl_dp.sv =====
// ----------------------------------------------------------------------------
// sacl_dp
// Lookup datapath: address split, set store, way scan, LRU update, counters.
// ----------------------------------------------------------------------------
module sacl_dp #(
   parameter int MAX_SET_BITS = 6,
   parameter int MAX_WAYS     = 8,
   parameter int ADDR_BITS    = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sacl_pkg::ctrl_cmd_type               cmd,
   output sacl_pkg::dp_status_type              status,
   input  logic [sacl_pkg::SET_BITS_W-1:0]      set_bits,
   input  logic [sacl_pkg::OFFSET_BITS_W-1:0]   offset_bits,
   input  logic [sacl_pkg::WAYS_USED_W-1:0]     ways_used,
   input  logic [sacl_pkg::ADDRESS_W-1:0]       req_address,
   output logic [sacl_pkg::OUTCOME_W-1:0]       rsp_outcome,
   output logic [sacl_pkg::WAY_OUT_W-1:0]       rsp_way_used,
   output logic [sacl_pkg::COUNT_W-1:0]         rsp_hits_total,
   output logic [sacl_pkg::COUNT_W-1:0]         rsp_misses_total,
   output logic [sacl_pkg::COUNT_W-1:0]         rsp_evictions_total
);

   localparam int NUM_SETS = 1 << MAX_SET_BITS;
   localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int NW_W     = WAY_W + 1;
   localparam int LINE_W   = 1 + WAY_W + ADDR_BITS;
   localparam int ROW_W    = MAX_WAYS * LINE_W;
   localparam int AGE_LSB  = ADDR_BITS;
   localparam int VLD_BIT  = ADDR_BITS + WAY_W;
   localparam logic [WAY_W-1:0] AGE_MAX = WAY_W'(MAX_WAYS - 1);

   // Accept cycle: split the address and start the set read.
   logic [ADDR_BITS-1:0]               addr_w;
   logic [sacl_pkg::SET_BITS_W-1:0]    sb_eff;
   logic [6:0]                         tag_shift;
   logic [ADDR_BITS-1:0]               tag_w;
   logic [ADDR_BITS-1:0]               set_full;
   logic [SET_W-1:0]                   set_mask;
   logic [SET_W-1:0]                   set_w;
   logic [4:0]                         nways_w;

   logic [ADDR_BITS-1:0] tag_ff, tag_in;
   logic [SET_W-1:0]     set_ff, set_in;
   logic [WAY_W-1:0]     last_way_ff, last_way_in;
   logic [SET_W-1:0]     clr_ff, clr_in;

   // Scan state.
   logic [WAY_W-1:0] way_ff, way_in;
   logic             hit_ff, hit_in;
   logic             full_ff, full_in;
   logic [WAY_W-1:0] hit_way_ff, hit_way_in;
   logic [WAY_W-1:0] hit_age_ff, hit_age_in;
   logic [WAY_W-1:0] empty_way_ff, empty_way_in;
   logic [WAY_W-1:0] victim_ff, victim_in;
   logic [WAY_W-1:0] vage_ff, vage_in;

   logic [ROW_W-1:0]  rd_row;
   logic [LINE_W-1:0] scan_line;
   logic              scan_vld;
   logic [WAY_W-1:0]  scan_age;
   logic              scan_match;
   logic              first;

   // Commit.
   sacl_pkg::outcome_type outcome_w;
   logic [WAY_W-1:0]      target_w;
   logic [NW_W-1:0]       limit_w;
   logic [ROW_W-1:0]      row_new;

   logic [sacl_pkg::COUNT_W-1:0] hits_ff, hits_in;
   logic [sacl_pkg::COUNT_W-1:0] misses_ff, misses_in;
   logic [sacl_pkg::COUNT_W-1:0] evicts_ff, evicts_in;
   sacl_pkg::outcome_type        outcome_ff, outcome_in;
   logic [sacl_pkg::WAY_OUT_W-1:0] way_out_ff, way_out_in;

   logic             ram_wr_en;
   logic [SET_W-1:0] ram_wr_addr;
   logic [ROW_W-1:0] ram_wr_data;

   // ---------------------------------------------------------------- split
   assign addr_w    = req_address[ADDR_BITS-1:0];
   assign sb_eff    = (32'(set_bits) > MAX_SET_BITS) ?
                      sacl_pkg::SET_BITS_W'(MAX_SET_BITS) : set_bits;
   assign tag_shift = 7'(sb_eff) + 7'(offset_bits);
   // A shift of the full width or more leaves a zero tag.
   assign tag_w     = addr_w >> tag_shift;
   assign set_full  = addr_w >> offset_bits;
   assign set_mask  = ~({SET_W{1'b1}} << sb_eff);
   assign set_w     = set_full[SET_W-1:0] & set_mask;

   always_comb begin
      if (ways_used == '0) begin
         nways_w = 5'd1;
      end else if ({1'b0, ways_used} > 5'(MAX_WAYS)) begin
         nways_w = 5'(MAX_WAYS);
      end else begin
         nways_w = {1'b0, ways_used};
      end
   end

   assign tag_in      = cmd.accept ? tag_w : tag_ff;
   assign set_in      = cmd.accept ? set_w : set_ff;
   assign last_way_in = cmd.accept ? WAY_W'(nways_w - 5'd1) : last_way_ff;
   assign clr_in      = cmd.clear_step ? clr_ff + SET_W'(1) : clr_ff;

   // ----------------------------------------------------------------- scan
   assign scan_line  = rd_row[way_ff*LINE_W +: LINE_W];
   assign scan_vld   = scan_line[VLD_BIT];
   assign scan_age   = scan_line[AGE_LSB +: WAY_W];
   assign scan_match = scan_vld && (scan_line[ADDR_BITS-1:0] == tag_ff);
   assign first      = (way_ff == '0);

   always_comb begin
      way_in       = way_ff;
      hit_in       = hit_ff;
      full_in      = full_ff;
      hit_way_in   = hit_way_ff;
      hit_age_in   = hit_age_ff;
      empty_way_in = empty_way_ff;
      victim_in    = victim_ff;
      vage_in      = vage_ff;
      if (cmd.accept) begin
         way_in = '0;
      end else if (cmd.scan_step) begin
         way_in  = way_ff + WAY_W'(1);
         hit_in  = first ? scan_match : (hit_ff || scan_match);
         full_in = first ? scan_vld : (full_ff && scan_vld);
         if (scan_match && (first || !hit_ff)) begin
            hit_way_in = way_ff;
            hit_age_in = scan_age;
         end
         if (!scan_vld) begin
            empty_way_in = way_ff;
         end
         // Oldest way wins; ties keep the lower way number.
         if (first || (scan_age > vage_ff)) begin
            victim_in = way_ff;
            vage_in   = scan_age;
         end
      end
   end

   assign status.scan_last  = (way_ff == last_way_ff);
   assign status.clear_last = (clr_ff == SET_W'(NUM_SETS - 1));

   // --------------------------------------------------------------- commit
   always_comb begin
      if (hit_ff) begin
         outcome_w = sacl_pkg::OUTCOME_HIT;
         target_w  = hit_way_ff;
         limit_w   = {1'b0, hit_age_ff};
      end else if (!full_ff) begin
         outcome_w = sacl_pkg::OUTCOME_FILL;
         target_w  = empty_way_ff;
         limit_w   = NW_W'(MAX_WAYS);
      end else begin
         outcome_w = sacl_pkg::OUTCOME_EVICT;
         target_w  = victim_ff;
         limit_w   = {1'b0, vage_ff};
      end
   end

   always_comb begin : row_update
      logic [LINE_W-1:0] line;
      logic [WAY_W-1:0]  age;
      logic              in_use;
      row_new = rd_row;
      for (int w = 0; w < MAX_WAYS; w++) begin
         line   = rd_row[w*LINE_W +: LINE_W];
         age    = line[AGE_LSB +: WAY_W];
         in_use = (WAY_W'(w) <= last_way_ff);
         if (WAY_W'(w) == target_w) begin
            line[AGE_LSB +: WAY_W] = '0;
            line[VLD_BIT]          = 1'b1;
            if (outcome_w != sacl_pkg::OUTCOME_HIT) begin
               line[ADDR_BITS-1:0] = tag_ff;
            end
         end else if (in_use && line[VLD_BIT] && ({1'b0, age} < limit_w) &&
                      (age < AGE_MAX)) begin
            line[AGE_LSB +: WAY_W] = age + WAY_W'(1);
         end
         row_new[w*LINE_W +: LINE_W] = line;
      end
   end

   always_comb begin
      hits_in    = hits_ff;
      misses_in  = misses_ff;
      evicts_in  = evicts_ff;
      outcome_in = outcome_ff;
      way_out_in = way_out_ff;
      if (cmd.commit) begin
         outcome_in = outcome_w;
         way_out_in = sacl_pkg::WAY_OUT_W'(target_w);
         if (outcome_w == sacl_pkg::OUTCOME_HIT) begin
            if (hits_ff != sacl_pkg::COUNT_MAX) begin
               hits_in = hits_ff + 32'd1;
            end
         end else begin
            if (misses_ff != sacl_pkg::COUNT_MAX) begin
               misses_in = misses_ff + 32'd1;
            end
            if ((outcome_w == sacl_pkg::OUTCOME_EVICT) && (evicts_ff != sacl_pkg::COUNT_MAX)) begin
               evicts_in = evicts_ff + 32'd1;
            end
         end
      end
   end

   // ---------------------------------------------------------------- store
   assign ram_wr_en   = cmd.clear_step || cmd.commit;
   assign ram_wr_addr = cmd.clear_step ? clr_ff : set_ff;
   assign ram_wr_data = cmd.clear_step ? '0 : row_new;

   sacl_ram #(
      .WIDTH (ROW_W),
      .DEPTH (NUM_SETS)
   ) u_set_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.accept),
      .rd_addr (set_w),
      .rd_data (rd_row)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff    <= '0;
         way_ff    <= '0;
         hits_ff   <= '0;
         misses_ff <= '0;
         evicts_ff <= '0;
      end else begin
         clr_ff    <= clr_in;
         way_ff    <= way_in;
         hits_ff   <= hits_in;
         misses_ff <= misses_in;
         evicts_ff <= evicts_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff       <= tag_in;
      set_ff       <= set_in;
      last_way_ff  <= last_way_in;
      hit_ff       <= hit_in;
      full_ff      <= full_in;
      hit_way_ff   <= hit_way_in;
      hit_age_ff   <= hit_age_in;
      empty_way_ff <= empty_way_in;
      victim_ff    <= victim_in;
      vage_ff      <= vage_in;
      outcome_ff   <= outcome_in;
      way_out_ff   <= way_out_in;
   end

   // Counters change only at a commit, which waits for the result register
   // to drain, so they can be shown directly.
   assign rsp_outcome         = outcome_ff;
   assign rsp_way_used        = way_out_ff;
   assign rsp_hits_total      = hits_ff;
   assign rsp_misses_total    = misses_ff;
   assign rsp_evictions_total = evicts_ff;

endmodule

// ===== tb/tb_set_assoc_lru_cache_lookup_top.sv =====
// ----------------------------------------------------------------------------
// Testbench for the set-associative LRU cache lookup block
// Sends address words through the request channel and checks every result
// word against a tag-store model kept in the testbench. A short list of
// directed accesses and register writes comes first. Random phases follow,
// each under its own register setting. Both channels idle at random, and
// once the response side holds off long enough to back up the request side.
// ----------------------------------------------------------------------------
module tb_set_assoc_lru_cache_lookup_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_SET_BITS  = 6;
   localparam int MAX_WAYS      = 8;
   localparam int NUM_LINES     = (1 << MAX_SET_BITS) * MAX_WAYS;
   localparam int PHASES        = 10;
   localparam int PHASE_ITEMS   = 55;
   localparam int HOLD_CYCLES   = 400;
   localparam int TAIL_CYCLES   = 30;
   localparam int CYCLE_LIMIT   = 300000;

   typedef struct packed {
      sacl_pkg::outcome_type                outcome;
      logic [sacl_pkg::WAY_OUT_W-1:0]       way;
      logic [sacl_pkg::COUNT_W-1:0]         hits;
      logic [sacl_pkg::COUNT_W-1:0]         misses;
      logic [sacl_pkg::COUNT_W-1:0]         evictions;
   } lookup_word_type;

   typedef struct {
      bit                             is_csr;
      logic [1:0]                     reg_index;
      logic [sacl_pkg::ADDRESS_W-1:0] value;
      bit                             typed;
      lookup_word_type                want;
   } stim_row_type;

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [sacl_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [sacl_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [sacl_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   sacl_req_if req_bus ();
   sacl_rsp_if rsp_bus ();

   set_assoc_lru_cache_lookup_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Model of the tag store and its register copy.
   logic [sacl_pkg::SET_BITS_W-1:0]    cfg_set_bits;
   logic [sacl_pkg::OFFSET_BITS_W-1:0] cfg_offset_bits;
   logic [sacl_pkg::WAYS_USED_W-1:0]   cfg_ways_used;
   bit                                 line_valid [NUM_LINES];
   logic [sacl_pkg::ADDRESS_W-1:0]     line_tag [NUM_LINES];
   int unsigned                        line_age [NUM_LINES];
   logic [sacl_pkg::COUNT_W-1:0]       hits_seen;
   logic [sacl_pkg::COUNT_W-1:0]       misses_seen;
   logic [sacl_pkg::COUNT_W-1:0]       evictions_seen;

   lookup_word_type pending_words [$];
   stim_row_type    rows [$];
   int              mismatch_count;
   bit              quiet;
   bit              hold_request;
   int              hold_left;
   int              stall_left;
   logic [sacl_pkg::ADDRESS_W-1:0] tag_pool [10];

   function automatic logic [sacl_pkg::COUNT_W-1:0] bump(logic [sacl_pkg::COUNT_W-1:0] v);
      return (v == sacl_pkg::COUNT_MAX) ? v : v + 1'b1;
   endfunction

   // The accessed way becomes most recent; younger valid ways age by one.
   function automatic void refresh_recency(int base, int nways, int way, bit was_valid);
      int unsigned limit;
      limit = was_valid ? line_age[base + way] : MAX_WAYS;
      for (int w = 0; w < nways; w++) begin
         if (w != way && line_valid[base + w] && line_age[base + w] < limit &&
             line_age[base + w] < MAX_WAYS - 1)
            line_age[base + w]++;
      end
      line_age[base + way] = 0;
   endfunction

   function automatic lookup_word_type predict_lookup(logic [sacl_pkg::ADDRESS_W-1:0] address);
      int sb, ob, nways, set_sel, base, hit_way, empty_way, victim;
      logic [sacl_pkg::ADDRESS_W-1:0] tag;
      bit hit, full;
      lookup_word_type r;
      sb = (cfg_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : cfg_set_bits;
      ob = cfg_offset_bits;
      nways = (cfg_ways_used == 0) ? 1 :
              (cfg_ways_used > MAX_WAYS) ? MAX_WAYS : cfg_ways_used;
      set_sel = int'((address >> ob) & ((64'd1 << sb) - 64'd1));
      tag = (sb + ob >= sacl_pkg::ADDRESS_W) ? '0 : address >> (sb + ob);
      base = set_sel * MAX_WAYS;
      hit = 0;
      full = 1;
      hit_way = 0;
      empty_way = 0;
      for (int w = 0; w < nways; w++) begin
         if (line_valid[base + w]) begin
            if (!hit && line_tag[base + w] == tag) begin
               hit = 1;
               hit_way = w;
            end
         end else begin
            full = 0;
            empty_way = w;
         end
      end
      if (hit) begin
         hits_seen = bump(hits_seen);
         refresh_recency(base, nways, hit_way, 1);
         r.outcome = sacl_pkg::OUTCOME_HIT;
         r.way = sacl_pkg::WAY_OUT_W'(hit_way);
      end else if (!full) begin
         misses_seen = bump(misses_seen);
         refresh_recency(base, nways, empty_way, 0);
         line_valid[base + empty_way] = 1;
         line_tag[base + empty_way] = tag;
         r.outcome = sacl_pkg::OUTCOME_FILL;
         r.way = sacl_pkg::WAY_OUT_W'(empty_way);
      end else begin
         misses_seen = bump(misses_seen);
         evictions_seen = bump(evictions_seen);
         victim = 0;
         for (int w = 1; w < nways; w++)
            if (line_age[base + w] > line_age[base + victim])
               victim = w;
         refresh_recency(base, nways, victim, 1);
         line_tag[base + victim] = tag;
         r.outcome = sacl_pkg::OUTCOME_EVICT;
         r.way = sacl_pkg::WAY_OUT_W'(victim);
      end
      r.hits = hits_seen;
      r.misses = misses_seen;
      r.evictions = evictions_seen;
      return r;
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60)
         return 0;
      else if (r < 92)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   // Addresses are built from a small pool of tags and a few sets so that
   // sets fill up, hit and evict; a share are fully random.
   function automatic logic [sacl_pkg::ADDRESS_W-1:0] make_address();
      int sb, ob;
      logic [sacl_pkg::ADDRESS_W-1:0] set_part, offset_part;
      sb = (cfg_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : cfg_set_bits;
      ob = cfg_offset_bits;
      if ($urandom_range(0, 99) < 15)
         return {$urandom, $urandom};
      set_part = $urandom_range(0, 3) & ((64'd1 << sb) - 64'd1);
      offset_part = {$urandom, $urandom} & ((64'd1 << ob) - 64'd1);
      return (tag_pool[$urandom_range(0, 9)] << (sb + ob)) | (set_part << ob) | offset_part;
   endfunction

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("tb: mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   task automatic add_csr(logic [1:0] reg_index, logic [sacl_pkg::ADDRESS_W-1:0] value);
      stim_row_type row;
      row = '{default: '0};
      row.is_csr = 1;
      row.reg_index = reg_index;
      row.value = value;
      rows.push_back(row);
   endtask

   task automatic add_lookup(logic [sacl_pkg::ADDRESS_W-1:0] address);
      stim_row_type row;
      row = '{default: '0};
      row.value = address;
      rows.push_back(row);
   endtask

   task automatic add_checked(logic [sacl_pkg::ADDRESS_W-1:0] address,
                              sacl_pkg::outcome_type outcome,
                              int way, int hits, int misses, int evictions);
      stim_row_type row;
      row = '{default: '0};
      row.value = address;
      row.typed = 1;
      row.want = '{outcome, sacl_pkg::WAY_OUT_W'(way), sacl_pkg::COUNT_W'(hits),
                   sacl_pkg::COUNT_W'(misses), sacl_pkg::COUNT_W'(evictions)};
      rows.push_back(row);
   endtask

   // Called at a falling edge; returns at a falling edge with valid still high.
   task automatic issue_lookup(logic [sacl_pkg::ADDRESS_W-1:0] address, bit typed,
                               lookup_word_type want);
      lookup_word_type predicted;
      req_bus.valid = 1'b1;
      req_bus.address = address;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      predicted = predict_lookup(address);
      pending_words.push_back(typed ? want : predicted);
      @(negedge clock);
   endtask

   task automatic pause_sender(int cycles);
      if (cycles > 0) begin
         req_bus.valid = 1'b0;
         repeat (cycles) @(negedge clock);
      end
   endtask

   task automatic drain();
      req_bus.valid = 1'b0;
      while (pending_words.size() != 0)
         @(negedge clock);
   endtask

   task automatic csr_write(logic [1:0] reg_index, logic [sacl_pkg::CSR_DATA_W-1:0] value);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = {reg_index, 2'b00};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      case (reg_index)
         sacl_pkg::REG_SET_BITS:    cfg_set_bits = value[sacl_pkg::SET_BITS_W-1:0];
         sacl_pkg::REG_OFFSET_BITS: cfg_offset_bits = value[sacl_pkg::OFFSET_BITS_W-1:0];
         sacl_pkg::REG_WAYS_USED:   cfg_ways_used = value[sacl_pkg::WAYS_USED_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   task automatic check_word();
      lookup_word_type want;
      if (pending_words.size() == 0) begin
         report("unexpected word, outcome", 64'(rsp_bus.outcome), 64'd0);
      end else begin
         want = pending_words.pop_front();
         if (rsp_bus.outcome !== want.outcome)
            report("outcome", 64'(rsp_bus.outcome), 64'(want.outcome));
         if (rsp_bus.way_used !== want.way)
            report("way_used", 64'(rsp_bus.way_used), 64'(want.way));
         if (rsp_bus.hits_total !== want.hits)
            report("hits_total", 64'(rsp_bus.hits_total), 64'(want.hits));
         if (rsp_bus.misses_total !== want.misses)
            report("misses_total", 64'(rsp_bus.misses_total), 64'(want.misses));
         if (rsp_bus.evictions_total !== want.evictions)
            report("evictions_total", 64'(rsp_bus.evictions_total), 64'(want.evictions));
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb: failure");
      $finish;
   end

   // Response side: random stalls, plus one long hold-off on request.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_bus.ready = 1'b0;
         end else if (hold_left > 0) begin
            rsp_bus.ready = 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_bus.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready = 1'b1;
            if ($urandom_range(0, 99) < 25)
               stall_left = idle_length();
         end
         @(posedge clock);
         if (hold_request) begin
            hold_request = 0;
            hold_left = HOLD_CYCLES;
         end
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready)
            check_word();
      end
   end

   initial begin
      int phase_sb [6];
      int phase_ob [6];
      int phase_ways [6];
      int sb, ob, ways;
      lookup_word_type none;

      phase_sb = '{0, 6, 7, 2, 0, 3};
      phase_ob = '{0, 63, 0, 4, 32, 6};
      phase_ways = '{1, 8, 15, 4, 0, 8};
      none = '0;

      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.address = '0;
      mismatch_count = 0;
      quiet = 0;
      hold_request = 0;
      hold_left = 0;
      stall_left = 0;
      cfg_set_bits = '0;
      cfg_offset_bits = '0;
      cfg_ways_used = sacl_pkg::WAYS_USED_RESET;
      hits_seen = '0;
      misses_seen = '0;
      evictions_seen = '0;
      for (int i = 0; i < NUM_LINES; i++) begin
         line_valid[i] = 0;
         line_tag[i] = '0;
         line_age[i] = 0;
      end

      // Reset setting: one way, the whole address is the tag.
      add_checked('0, sacl_pkg::OUTCOME_FILL, 0, 0, 1, 0);
      add_checked('0, sacl_pkg::OUTCOME_HIT, 0, 1, 1, 0);
      add_checked('1, sacl_pkg::OUTCOME_EVICT, 0, 1, 2, 1);
      add_checked('1, sacl_pkg::OUTCOME_HIT, 0, 2, 2, 1);
      // Widest setting: fill the free ways from the top, then hit one of them.
      add_csr(sacl_pkg::REG_SET_BITS, 64'd6);
      add_csr(sacl_pkg::REG_OFFSET_BITS, 64'd6);
      add_csr(sacl_pkg::REG_WAYS_USED, 64'd8);
      for (int i = 0; i < 8; i++)
         add_lookup(64'h1000 * i);
      add_lookup(64'h3000);
      // Out-of-range settings: set bits beyond the limit, a shift that leaves
      // no tag, and zero ways; lines in the ways now unused stay put.
      add_csr(sacl_pkg::REG_SET_BITS, 64'd7);
      add_csr(sacl_pkg::REG_OFFSET_BITS, 64'd63);
      add_csr(sacl_pkg::REG_WAYS_USED, 64'd0);
      add_lookup('1);
      add_lookup(64'h8000_0000_0000_0000);
      add_lookup('0);
      add_csr(sacl_pkg::REG_WAYS_USED, 64'd15);
      add_csr(sacl_pkg::REG_OFFSET_BITS, 64'd0);
      add_csr(sacl_pkg::REG_SET_BITS, 64'd0);
      add_lookup(64'h5555_5555_5555_5555);
      add_lookup(64'hAAAA_AAAA_AAAA_AAAA);
      add_csr(sacl_pkg::REG_OFFSET_BITS, 64'd32);
      add_csr(sacl_pkg::REG_SET_BITS, 64'd3);
      add_lookup(64'h0000_0001_0000_0000);
      add_lookup(64'hFFFF_FFF8_0000_0000);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (rows[i]) begin
         if (rows[i].is_csr) begin
            drain();
            csr_write(rows[i].reg_index, rows[i].value[sacl_pkg::CSR_DATA_W-1:0]);
         end else begin
            issue_lookup(rows[i].value, rows[i].typed, rows[i].want);
            pause_sender(idle_length());
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         if (p < 6) begin
            sb = phase_sb[p];
            ob = phase_ob[p];
            ways = phase_ways[p];
         end else begin
            sb = $urandom_range(0, 7);
            ob = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 20);
            ways = $urandom_range(0, 15);
         end
         drain();
         csr_write(sacl_pkg::REG_SET_BITS, sb);
         csr_write(sacl_pkg::REG_OFFSET_BITS, ob);
         csr_write(sacl_pkg::REG_WAYS_USED, ways);
         quiet = (p == 3 || p == 7);
         foreach (tag_pool[i])
            tag_pool[i] = ($urandom_range(0, 2) == 0) ? {$urandom, $urandom} :
                                                        $urandom_range(0, 15);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // With the response side held off, keep offering words until the
            // block backs up.
            if (p == 2 && n == 20)
               hold_request = 1;
            issue_lookup(make_address(), 0, none);
            if (!(p == 2 && n >= 20 && n < 35))
               pause_sender(idle_length());
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
